// ===== design/vdp_pkg.sv =====
// Shared types, codes and constants for the VGA DAC palette block.
// Holds the reset contents of the palette as a function.
// No dependencies.
package vdp_pkg;

  localparam int ACT_W    = 2;
  localparam int SEL_W    = 2;
  localparam int BYTE_W   = 8;
  localparam int IDX_W    = 8;
  localparam int COMP_W   = 6;
  localparam int COLOUR_W = 24;
  localparam int PAL_DEPTH = 1 << IDX_W;

  // Actions carried by an input word.
  localparam logic [ACT_W-1:0] ACT_PORT_WR = 2'd0;
  localparam logic [ACT_W-1:0] ACT_PORT_RD = 2'd1;
  localparam logic [ACT_W-1:0] ACT_SET     = 2'd2;
  localparam logic [ACT_W-1:0] ACT_LOOKUP  = 2'd3;

  // Port selectors.
  localparam logic [SEL_W-1:0] PORT_RIDX = 2'd0;
  localparam logic [SEL_W-1:0] PORT_WIDX = 2'd1;
  localparam logic [SEL_W-1:0] PORT_DATA = 2'd2;

  // Component positions of the shared counter.
  localparam logic [1:0] COMP_RED   = 2'd0;
  localparam logic [1:0] COMP_GREEN = 2'd1;
  localparam logic [1:0] COMP_BLUE  = 2'd2;

  localparam logic [BYTE_W-1:0] NO_PORT_BYTE = 8'hFF;

  typedef struct packed {
    logic accept;   // an input word is taken this cycle
    logic compute;  // the result register loads this cycle
  } vdp_cmd_t;

  // Palette contents after reset: EGA colours, then a grey ramp.
  function automatic logic [COLOUR_W-1:0] pal_reset_entry(input logic [IDX_W-1:0] idx);
    logic [COLOUR_W-1:0] c;
    case (idx)
      8'd0:    c = 24'h000000;
      8'd1:    c = 24'h0000AA;
      8'd2:    c = 24'h00AA00;
      8'd3:    c = 24'h00AAAA;
      8'd4:    c = 24'hAA0000;
      8'd5:    c = 24'hAA00AA;
      8'd6:    c = 24'hAA5500;
      8'd7:    c = 24'hAAAAAA;
      8'd8:    c = 24'h555555;
      8'd9:    c = 24'h5555FF;
      8'd10:   c = 24'h55FF55;
      8'd11:   c = 24'h55FFFF;
      8'd12:   c = 24'hFF5555;
      8'd13:   c = 24'hFF55FF;
      8'd14:   c = 24'hFFFF55;
      8'd15:   c = 24'hFFFFFF;
      default: c = {idx, idx, idx};
    endcase
    return c;
  endfunction

  // 6-bit components stored scaled to 8 bits each.
  function automatic logic [COLOUR_W-1:0] pal_scale(input logic [COMP_W-1:0] r,
                                                    input logic [COMP_W-1:0] g,
                                                    input logic [COMP_W-1:0] b);
    return {r, 2'b00, g, 2'b00, b, 2'b00};
  endfunction

endpackage

// ===== design/vdp_if.sv =====
// Valid/ready channel interfaces for the palette block's input and result words.
// Depends on vdp_pkg for field widths.
interface vdp_in_if import vdp_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [ACT_W-1:0]    action;
  logic [SEL_W-1:0]    port_sel;
  logic [BYTE_W-1:0]   port_data;
  logic [IDX_W-1:0]    entry_index;
  logic [COMP_W-1:0]   red;
  logic [COMP_W-1:0]   green;
  logic [COMP_W-1:0]   blue;

  modport source (output valid, action, port_sel, port_data, entry_index, red, green, blue,
                  input ready);
  modport sink (input valid, action, port_sel, port_data, entry_index, red, green, blue,
                output ready);
endinterface

interface vdp_out_if import vdp_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [BYTE_W-1:0]   read_data;
  logic [COLOUR_W-1:0] colour;

  modport source (output valid, read_data, colour, input ready);
  modport sink (input valid, read_data, colour, output ready);
endinterface

// ===== design/vdp_ctrl.sv =====
// Controller of the palette block: sequences accept, compute and deliver.
// Depends on vdp_pkg for the command struct.
module vdp_ctrl import vdp_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  output vdp_cmd_t cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CALC = 2'd1;
  localparam logic [1:0] S_OUT  = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  assign in_ready    = (state_r == S_IDLE);
  assign out_valid   = (state_r == S_OUT);
  assign cmd.accept  = in_valid && in_ready;
  assign cmd.compute = (state_r == S_CALC);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_CALC;
      end
      S_CALC: begin
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_ready) state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

endmodule

// ===== design/vdp_datapath.sv =====
// Datapath of the palette block: palette memory, port indices, component
// counter and latches, and the result register. Depends on vdp_pkg.
module vdp_datapath import vdp_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  vdp_cmd_t            cmd,
  input  logic [ACT_W-1:0]    action,
  input  logic [SEL_W-1:0]    port_sel,
  input  logic [BYTE_W-1:0]   port_data,
  input  logic [IDX_W-1:0]    entry_index,
  input  logic [COMP_W-1:0]   red,
  input  logic [COMP_W-1:0]   green,
  input  logic [COMP_W-1:0]   blue,
  output logic [BYTE_W-1:0]   read_data,
  output logic [COLOUR_W-1:0] colour
);

  logic [COLOUR_W-1:0] pal_mem [PAL_DEPTH];
  logic [PAL_DEPTH-1:0] pal_vld_r;

  logic [IDX_W-1:0]  widx_r;
  logic [IDX_W-1:0]  ridx_r;
  logic [1:0]        step_r;
  logic [COMP_W-1:0] latch_r [3];

  // Per-word information carried from accept to compute.
  logic [COLOUR_W-1:0] rdata_r;
  logic                rvld_r;
  logic [IDX_W-1:0]    raddr_r;
  logic                from_mem_r;
  logic                look_r;
  logic [1:0]          comp_r;
  logic [BYTE_W-1:0]   rd_direct_r;
  logic [BYTE_W-1:0]   read_data_r;
  logic [COLOUR_W-1:0] colour_r;

  logic                we;
  logic [IDX_W-1:0]    waddr;
  logic [COLOUR_W-1:0] wdata;
  logic [IDX_W-1:0]    raddr;
  logic [COLOUR_W-1:0] entry;
  logic [COMP_W-1:0]   comp_val;

  // A direct set and the third data-port write are the only palette writes.
  always_comb begin
    we    = 1'b0;
    waddr = widx_r;
    wdata = pal_scale(latch_r[0], latch_r[1], port_data[COMP_W-1:0]);
    if (cmd.accept) begin
      if (action == ACT_SET) begin
        we    = 1'b1;
        waddr = entry_index;
        wdata = pal_scale(red, green, blue);
      end else if (action == ACT_PORT_WR && port_sel == PORT_DATA && step_r == COMP_BLUE) begin
        we = 1'b1;
      end
    end
  end

  assign raddr = (action == ACT_LOOKUP) ? entry_index : ridx_r;

  always_ff @(posedge clk) begin
    if (we) pal_mem[waddr] <= wdata;
    if (cmd.accept) begin
      rdata_r <= pal_mem[raddr];
      raddr_r <= raddr;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pal_vld_r   <= '0;
      widx_r      <= '0;
      ridx_r      <= '0;
      step_r      <= COMP_RED;
      latch_r[0]  <= '0;
      latch_r[1]  <= '0;
      latch_r[2]  <= '0;
      rvld_r      <= 1'b0;
      from_mem_r  <= 1'b0;
      look_r      <= 1'b0;
      comp_r      <= COMP_RED;
      rd_direct_r <= '0;
    end else begin
      if (we) pal_vld_r[waddr] <= 1'b1;
      if (cmd.accept) begin
        rvld_r      <= pal_vld_r[raddr];
        from_mem_r  <= 1'b0;
        look_r      <= 1'b0;
        comp_r      <= step_r;
        rd_direct_r <= '0;
        case (action)
          ACT_PORT_WR: begin
            case (port_sel)
              PORT_WIDX: begin
                widx_r <= port_data;
                step_r <= COMP_RED;
              end
              PORT_RIDX: begin
                ridx_r <= port_data;
                step_r <= COMP_RED;
              end
              PORT_DATA: begin
                case (step_r)
                  COMP_RED: begin
                    latch_r[0] <= port_data[COMP_W-1:0];
                    step_r     <= COMP_GREEN;
                  end
                  COMP_GREEN: begin
                    latch_r[1] <= port_data[COMP_W-1:0];
                    step_r     <= COMP_BLUE;
                  end
                  default: begin
                    latch_r[2] <= port_data[COMP_W-1:0];
                    widx_r     <= widx_r + 1'b1;
                    step_r     <= COMP_RED;
                  end
                endcase
              end
              default: begin
              end
            endcase
          end
          ACT_PORT_RD: begin
            case (port_sel)
              PORT_WIDX: begin
                rd_direct_r <= widx_r;
              end
              PORT_DATA: begin
                from_mem_r <= 1'b1;
                case (step_r)
                  COMP_RED:   step_r <= COMP_GREEN;
                  COMP_GREEN: step_r <= COMP_BLUE;
                  default: begin
                    step_r <= COMP_RED;
                    ridx_r <= ridx_r + 1'b1;
                  end
                endcase
              end
              default: begin
                rd_direct_r <= NO_PORT_BYTE;
              end
            endcase
          end
          ACT_LOOKUP: begin
            look_r <= 1'b1;
          end
          default: begin
          end
        endcase
      end
    end
  end

  // An entry never written still holds its power-up colour.
  assign entry = rvld_r ? rdata_r : pal_reset_entry(raddr_r);

  always_comb begin
    case (comp_r)
      COMP_RED:   comp_val = entry[23:18];
      COMP_GREEN: comp_val = entry[15:10];
      default:    comp_val = entry[7:2];
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.compute) begin
      read_data_r <= from_mem_r ? {2'b00, comp_val} : rd_direct_r;
      colour_r    <= look_r ? entry : '0;
    end
  end

  assign read_data = read_data_r;
  assign colour    = colour_r;

endmodule

// ===== design/vga_dac_palette_ports_top.sv =====
// VGA DAC palette with index and data ports; top level.
// Uses the channel interfaces, vdp_ctrl, vdp_datapath and vdp_pkg.
//
// Usage: each input word carries an action (port write, port read, direct
// entry set or colour lookup) with its port selector, port byte, entry index
// and 6-bit components. Every input word yields exactly one result word with
// the byte of a port read and the 24-bit colour of a lookup, the unused
// field being zero.
// Sequence: the registered read of the 256-entry palette memory takes the
// input word at accept, the result register then loads, and the result word
// is then valid. One word is handled at a time, so no new input word is
// taken until the result word of the last one has been taken.
// Reset (synchronous, rst_n low) zeroes the indices, the component counter
// and the latches, and marks all palette entries unwritten, so they read as
// the sixteen EGA colours followed by a grey ramp with no clearing pass.
// When the receiver stalls, the result word holds and no new input word is
// accepted until it is taken.
module vga_dac_palette_ports_top import vdp_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  vdp_in_if.sink    in_ch,
  vdp_out_if.source out_ch
);

  vdp_cmd_t cmd;

  vdp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd)
  );

  vdp_datapath u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .action      (in_ch.action),
    .port_sel    (in_ch.port_sel),
    .port_data   (in_ch.port_data),
    .entry_index (in_ch.entry_index),
    .red         (in_ch.red),
    .green       (in_ch.green),
    .blue        (in_ch.blue),
    .read_data   (out_ch.read_data),
    .colour      (out_ch.colour)
  );

endmodule

// ===== tb/vga_dac_palette_ports_top_tb.sv =====
// Self-checking testbench for vga_dac_palette_ports_top: a directed table, then random port traffic.
// A local palette model predicts the result word of every untyped word. Random gaps are placed on both channels.
// Depends on vdp_pkg, vdp_if and the design under design/.
module vga_dac_palette_ports_top_tb import vdp_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [SEL_W-1:0] PORT_NONE = 2'd3;
  localparam int unsigned TOTAL_WORDS = 1425;

  localparam logic [COLOUR_W-1:0] EGA_RGB [16] = '{
    24'h000000, 24'h0000AA, 24'h00AA00, 24'h00AAAA,
    24'hAA0000, 24'hAA00AA, 24'hAA5500, 24'hAAAAAA,
    24'h555555, 24'h5555FF, 24'h55FF55, 24'h55FFFF,
    24'hFF5555, 24'hFF55FF, 24'hFFFF55, 24'hFFFFFF
  };

  typedef struct packed {
    logic [ACT_W-1:0]  action;
    logic [SEL_W-1:0]  port_sel;
    logic [BYTE_W-1:0] port_data;
    logic [IDX_W-1:0]  entry_index;
    logic [COMP_W-1:0] red;
    logic [COMP_W-1:0] green;
    logic [COMP_W-1:0] blue;
  } dac_word_t;

  typedef struct packed {
    logic [BYTE_W-1:0]   read_data;
    logic [COLOUR_W-1:0] colour;
  } dac_result_t;

  typedef struct packed {
    logic [ACT_W-1:0]    action;
    logic [SEL_W-1:0]    port_sel;
    logic [BYTE_W-1:0]   port_data;
    logic [IDX_W-1:0]    entry_index;
    logic [COMP_W-1:0]   red;
    logic [COMP_W-1:0]   green;
    logic [COMP_W-1:0]   blue;
    logic                typed;
    logic [BYTE_W-1:0]   want_rd;
    logic [COLOUR_W-1:0] want_col;
  } dir_row_t;

  // The typed rows follow from the reset palette and from the words before them.
  dir_row_t dir_rows [25] = '{
    '{ACT_LOOKUP,  PORT_RIDX, 8'h00, 8'd0,   6'd0,  6'd0,  6'd0,  1'b1, 8'h00, 24'h000000},
    '{ACT_LOOKUP,  PORT_RIDX, 8'h00, 8'd1,   6'd0,  6'd0,  6'd0,  1'b1, 8'h00, 24'h0000AA},
    '{ACT_LOOKUP,  PORT_RIDX, 8'h00, 8'd15,  6'd0,  6'd0,  6'd0,  1'b1, 8'h00, 24'hFFFFFF},
    '{ACT_LOOKUP,  PORT_RIDX, 8'h00, 8'd16,  6'd0,  6'd0,  6'd0,  1'b1, 8'h00, 24'h101010},
    '{ACT_LOOKUP,  PORT_RIDX, 8'h00, 8'd255, 6'd0,  6'd0,  6'd0,  1'b1, 8'h00, 24'hFFFFFF},
    '{ACT_PORT_RD, PORT_WIDX, 8'h00, 8'd0,   6'd0,  6'd0,  6'd0,  1'b1, 8'h00, 24'h000000},
    '{ACT_PORT_RD, PORT_RIDX, 8'h00, 8'd0,   6'd0,  6'd0,  6'd0,  1'b1, 8'hFF, 24'h000000},
    '{ACT_PORT_RD, PORT_NONE, 8'h00, 8'd0,   6'd0,  6'd0,  6'd0,  1'b1, 8'hFF, 24'h000000},
    '{ACT_PORT_WR, PORT_RIDX, 8'h04, 8'd0,   6'd0,  6'd0,  6'd0,  1'b1, 8'h00, 24'h000000},
    '{ACT_PORT_RD, PORT_DATA, 8'h00, 8'd0,   6'd0,  6'd0,  6'd0,  1'b1, 8'h2A, 24'h000000},
    '{ACT_PORT_RD, PORT_DATA, 8'h00, 8'd0,   6'd0,  6'd0,  6'd0,  1'b1, 8'h00, 24'h000000},
    '{ACT_PORT_RD, PORT_DATA, 8'h00, 8'd0,   6'd0,  6'd0,  6'd0,  1'b1, 8'h00, 24'h000000},
    '{ACT_PORT_WR, PORT_WIDX, 8'hFF, 8'd0,   6'd0,  6'd0,  6'd0,  1'b1, 8'h00, 24'h000000},
    '{ACT_PORT_WR, PORT_DATA, 8'hFF, 8'd0,   6'd0,  6'd0,  6'd0,  1'b1, 8'h00, 24'h000000},
    '{ACT_PORT_WR, PORT_DATA, 8'hC0, 8'd0,   6'd0,  6'd0,  6'd0,  1'b1, 8'h00, 24'h000000},
    '{ACT_PORT_WR, PORT_DATA, 8'h3F, 8'd0,   6'd0,  6'd0,  6'd0,  1'b1, 8'h00, 24'h000000},
    '{ACT_LOOKUP,  PORT_RIDX, 8'h00, 8'd255, 6'd0,  6'd0,  6'd0,  1'b1, 8'h00, 24'hFC00FC},
    '{ACT_PORT_RD, PORT_WIDX, 8'h00, 8'd0,   6'd0,  6'd0,  6'd0,  1'b1, 8'h00, 24'h000000},
    '{ACT_PORT_WR, PORT_NONE, 8'hFF, 8'd0,   6'd0,  6'd0,  6'd0,  1'b1, 8'h00, 24'h000000},
    '{ACT_SET,     PORT_RIDX, 8'h00, 8'd0,   6'h3F, 6'h00, 6'h3F, 1'b1, 8'h00, 24'h000000},
    '{ACT_LOOKUP,  PORT_RIDX, 8'h00, 8'd0,   6'd0,  6'd0,  6'd0,  1'b1, 8'h00, 24'hFC00FC},
    '{ACT_PORT_WR, PORT_RIDX, 8'hFF, 8'd0,   6'd0,  6'd0,  6'd0,  1'b1, 8'h00, 24'h000000},
    '{ACT_PORT_WR, PORT_DATA, 8'h2A, 8'd0,   6'd0,  6'd0,  6'd0,  1'b0, 8'h00, 24'h000000},
    '{ACT_PORT_RD, PORT_DATA, 8'h00, 8'd0,   6'd0,  6'd0,  6'd0,  1'b0, 8'h00, 24'h000000},
    '{ACT_PORT_RD, PORT_DATA, 8'h00, 8'd0,   6'd0,  6'd0,  6'd0,  1'b0, 8'h00, 24'h000000}
  };

  logic clk = 1'b0;
  logic rst_n;

  vdp_in_if  in_ch ();
  vdp_out_if out_ch ();

  vga_dac_palette_ports_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Local copy of the palette and the port registers.
  logic [COLOUR_W-1:0] pal_mem [PAL_DEPTH];
  logic [IDX_W-1:0]    wr_idx;
  logic [IDX_W-1:0]    rd_idx;
  logic [1:0]          comp_pos;
  logic [COMP_W-1:0]   comp_hold [3];

  dac_result_t dac_results_due [$];
  int unsigned mismatch_cnt = 0;
  int unsigned words_sent = 0;
  bit          sender_calm = 1'b0;

  function automatic logic [COLOUR_W-1:0] widen_rgb(input logic [COMP_W-1:0] r,
                                                    input logic [COMP_W-1:0] g,
                                                    input logic [COMP_W-1:0] b);
    return (COLOUR_W'(r) << 18) | (COLOUR_W'(g) << 10) | (COLOUR_W'(b) << 2);
  endfunction

  // Applies one word to the local state and returns the result word it causes.
  function automatic dac_result_t dac_predict(input dac_word_t w);
    dac_result_t res;
    logic [COLOUR_W-1:0] ent;
    res = '0;
    case (w.action)
      ACT_PORT_WR: begin
        if (w.port_sel == PORT_WIDX) begin
          wr_idx = w.port_data;
          comp_pos = COMP_RED;
        end else if (w.port_sel == PORT_RIDX) begin
          rd_idx = w.port_data;
          comp_pos = COMP_RED;
        end else if (w.port_sel == PORT_DATA) begin
          comp_hold[comp_pos] = w.port_data[COMP_W-1:0];
          if (comp_pos == COMP_BLUE) begin
            pal_mem[wr_idx] = widen_rgb(comp_hold[0], comp_hold[1], comp_hold[2]);
            wr_idx = wr_idx + 1'b1;
            comp_pos = COMP_RED;
          end else begin
            comp_pos = comp_pos + 1'b1;
          end
        end
      end
      ACT_PORT_RD: begin
        if (w.port_sel == PORT_WIDX) begin
          res.read_data = wr_idx;
        end else if (w.port_sel != PORT_DATA) begin
          res.read_data = NO_PORT_BYTE;
        end else begin
          ent = pal_mem[rd_idx];
          // Reads share the component position with data writes.
          case (comp_pos)
            COMP_RED: begin
              res.read_data = {2'b00, ent[23:18]};
              comp_pos = COMP_GREEN;
            end
            COMP_GREEN: begin
              res.read_data = {2'b00, ent[15:10]};
              comp_pos = COMP_BLUE;
            end
            default: begin
              res.read_data = {2'b00, ent[7:2]};
              rd_idx = rd_idx + 1'b1;
              comp_pos = COMP_RED;
            end
          endcase
        end
      end
      ACT_SET: pal_mem[w.entry_index] = widen_rgb(w.red, w.green, w.blue);
      default: res.colour = pal_mem[w.entry_index];
    endcase
    return res;
  endfunction

  // Mostly short gaps, a few long ones, none during a calm stretch.
  function automatic int unsigned pick_gap(input bit calm);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (calm || roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic dac_word_t scramble_word();
    dac_word_t w;
    w.action      = ACT_W'($urandom_range(0, 3));
    w.port_sel    = SEL_W'($urandom_range(0, 3));
    w.port_data   = BYTE_W'($urandom_range(0, 255));
    w.entry_index = IDX_W'($urandom_range(0, 255));
    w.red         = COMP_W'($urandom_range(0, 63));
    w.green       = COMP_W'($urandom_range(0, 63));
    w.blue        = COMP_W'($urandom_range(0, 63));
    return w;
  endfunction

  // Index start values lean toward the top so that wrapping is exercised often.
  function automatic logic [BYTE_W-1:0] pick_index();
    if ($urandom_range(0, 3) == 0) return BYTE_W'($urandom_range(250, 255));
    return BYTE_W'($urandom_range(0, 255));
  endfunction

  // Offers one word, waits for it to be taken, records its expected result, then may idle for a random gap.
  task automatic push_word(input dac_word_t w, input bit typed, input dac_result_t typed_res);
    dac_result_t pred;
    int unsigned gap;
    in_ch.valid       <= 1'b1;
    in_ch.action      <= w.action;
    in_ch.port_sel    <= w.port_sel;
    in_ch.port_data   <= w.port_data;
    in_ch.entry_index <= w.entry_index;
    in_ch.red         <= w.red;
    in_ch.green       <= w.green;
    in_ch.blue        <= w.blue;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    pred = dac_predict(w);
    dac_results_due.push_back(typed ? typed_res : pred);
    if (!(w.action == ACT_PORT_WR && w.port_sel == PORT_NONE)) words_sent++;
    gap = pick_gap(sender_calm);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  initial begin : stimulus
    dac_word_t w;
    dir_row_t row;
    int unsigned kind;
    int unsigned n;
    rst_n             <= 1'b0;
    in_ch.valid       <= 1'b0;
    in_ch.action      <= ACT_PORT_WR;
    in_ch.port_sel    <= PORT_RIDX;
    in_ch.port_data   <= '0;
    in_ch.entry_index <= '0;
    in_ch.red         <= '0;
    in_ch.green       <= '0;
    in_ch.blue        <= '0;
    for (int i = 0; i < PAL_DEPTH; i++) begin
      pal_mem[i] = (i < 16) ? EGA_RGB[i] : COLOUR_W'(i * 32'h010101);
    end
    wr_idx = '0;
    rd_idx = '0;
    comp_pos = COMP_RED;
    comp_hold = '{default: '0};
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      w.action      = row.action;
      w.port_sel    = row.port_sel;
      w.port_data   = row.port_data;
      w.entry_index = row.entry_index;
      w.red         = row.red;
      w.green       = row.green;
      w.blue        = row.blue;
      push_word(w, row.typed, {row.want_rd, row.want_col});
    end

    while (words_sent < TOTAL_WORDS) begin
      kind = $urandom_range(0, 99);
      sender_calm = ($urandom_range(0, 5) == 0);
      if (kind < 30) begin
        // Load entries: write index, then red, green, blue triplets, sometimes cut short by one or two components.
        w = scramble_word();
        w.action = ACT_PORT_WR;
        w.port_sel = PORT_WIDX;
        w.port_data = pick_index();
        push_word(w, 1'b0, '0);
        n = $urandom_range(1, 4) * 3;
        if ($urandom_range(0, 9) == 0) n = n - $urandom_range(1, 2);
        repeat (n) begin
          w = scramble_word();
          w.action = ACT_PORT_WR;
          w.port_sel = PORT_DATA;
          push_word(w, 1'b0, '0);
        end
      end else if (kind < 55) begin
        // Read entries back through the read index and the data port.
        w = scramble_word();
        w.action = ACT_PORT_WR;
        w.port_sel = PORT_RIDX;
        w.port_data = pick_index();
        push_word(w, 1'b0, '0);
        n = $urandom_range(1, 4) * 3;
        repeat (n) begin
          w = scramble_word();
          w.action = ($urandom_range(0, 11) == 0) ? ACT_PORT_WR : ACT_PORT_RD;
          w.port_sel = PORT_DATA;
          push_word(w, 1'b0, '0);
        end
      end else if (kind < 75) begin
        repeat ($urandom_range(1, 8)) begin
          w = scramble_word();
          w.action = ACT_LOOKUP;
          push_word(w, 1'b0, '0);
        end
      end else if (kind < 85) begin
        w = scramble_word();
        w.action = ACT_SET;
        push_word(w, 1'b0, '0);
        if ($urandom_range(0, 1) == 0) begin
          w.action = ACT_LOOKUP;
          push_word(w, 1'b0, '0);
        end
      end else if (kind < 92) begin
        w = scramble_word();
        w.action = ACT_PORT_RD;
        case ($urandom_range(0, 2))
          0: w.port_sel = PORT_RIDX;
          1: w.port_sel = PORT_WIDX;
          default: w.port_sel = PORT_NONE;
        endcase
        push_word(w, 1'b0, '0);
      end else begin
        repeat ($urandom_range(1, 4)) push_word(scramble_word(), 1'b0, '0);
      end
    end
    in_ch.valid <= 1'b0;

    while (dac_results_due.size() != 0) @(posedge clk);
    // Leave room for any stray result word after the last expected one.
    repeat (8) @(posedge clk);
    if (mismatch_cnt == 0 && dac_results_due.size() == 0) begin
      $display("vga_dac_palette_ports_top verification clean");
    end else begin
      $display("vga_dac_palette_ports_top verification failed");
    end
    $finish;
  end

  // Receiver stalls: calm stretches always ready, otherwise random low periods.
  // Every pass of the loop drives ready at its start, so it is set from time zero.
  initial begin : result_stall
    int unsigned lo;
    forever begin
      if ($urandom_range(0, 5) == 0) begin
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(20, 80)) @(posedge clk);
      end else begin
        lo = pick_gap(1'b0);
        if (lo > 0) begin
          out_ch.ready <= 1'b0;
          repeat (lo) @(posedge clk);
        end
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 4)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin : result_check
    dac_result_t want;
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (dac_results_due.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10) begin
          $display("%0t: result word with none expected: read_data %h colour %h",
                   $time, out_ch.read_data, out_ch.colour);
        end
      end else begin
        want = dac_results_due.pop_front();
        if (out_ch.read_data !== want.read_data || out_ch.colour !== want.colour) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10) begin
            $display("%0t: read_data exp %h got %h, colour exp %h got %h", $time,
                     want.read_data, out_ch.read_data, want.colour, out_ch.colour);
          end
        end
      end
    end
  end

  initial begin : watchdog
    #20_000_000;
    $display("vga_dac_palette_ports_top verification failed");
    $finish;
  end

endmodule

// ===== vga_dac_palette_ports_top.f =====
design/vdp_pkg.sv
design/vdp_if.sv
design/vdp_ctrl.sv
design/vdp_datapath.sv
design/vga_dac_palette_ports_top.sv
tb/vga_dac_palette_ports_top_tb.sv
